// File: design/tplc_pkg.sv
// shared types and constants for the two-point linear calibration unit
package tplc_pkg;

    // arithmetic word width
    localparam int unsigned WORD_W = 32;
    localparam int unsigned CODE_W = 31;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned STEP_W = 5;

    // operation codes
    typedef enum logic [1:0] {
        OP_COEF   = 2'd0,
        OP_TO_CODE = 2'd1,
        OP_TO_VAL = 2'd2,
        OP_NOP    = 2'd3
    } opcode_t;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_P1_CODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_P1_VALUE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_P2_CODE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_P2_VALUE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE    = 3'd4;

    // input and result words
    typedef struct packed {
        logic [1:0]              opcode;
        logic signed [WORD_W-1:0] value_in;
        logic [CODE_W-1:0]       code_in;
    } in_item_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] result;
        logic                    status;
    } out_item_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL,
        ST_ADJ,
        ST_DIV_INIT,
        ST_DIV,
        ST_FIX,
        ST_RND,
        ST_ICPT_A,
        ST_ICPT_B,
        ST_ICPT_C,
        ST_OUT
    } state_t;

endpackage

// File: design/two_point_linear_calibration.sv
// two-point linear calibration unit with one shared multiplier and a radix-2 divider
//
// Usage: configuration words go in on cfg_valid/cfg_ready (ready out of reset) with a
// register index (0 p1_code, 1 p1_value, 2 p2_code, 3 p2_value, 4 scale) and
// data; write them only while the block is idle. One input word on
// s_valid/s_ready carries an opcode: 0 computes and stores gain and intercept
// and returns the gain, 1 turns value_in into a code, 2 turns code_in into a
// value, 3 returns zero. The result word comes out on m_valid/m_ready with a
// status bit that flags a zero divisor (result then zero).
// Opcode 0 runs prep, multiply, divider, sign fix, round and intercept states,
// opcodes 1 and 2 run multiply, intercept adjust, divider, sign fix and round,
// opcode 3 goes straight to the result; a zero divisor skips the divider.
// The restoring divider runs 32 steps; multiplies use the shared multiplier.
// One word is in flight at a time: s_ready is high only when idle, so a new
// word is taken only after the previous result has been taken.
// A stalled receiver holds the result register and keeps s_ready low.
// Synchronous reset clears the sequencer, gain and intercept, zeroes the
// calibration points and sets scale to 1; both ready outputs are low in reset.
module two_point_linear_calibration
    import tplc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration port
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [WORD_W-1:0]     cfg_data,
    // input channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    // result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data
);

    // configuration and persistent state
    logic [CODE_W-1:0]  p1_code_reg, p2_code_reg, scale_reg;
    logic [WORD_W-1:0]  p1_value_reg, p2_value_reg;
    logic [WORD_W-1:0]  gain_reg, gain_next;
    logic [WORD_W-1:0]  icpt_reg, icpt_next;

    // sequencer and datapath registers
    state_t             state_reg, state_next;
    opcode_t            op_reg, op_next;
    logic [WORD_W-1:0]  vin_reg, vin_next;
    logic [CODE_W-1:0]  cin_reg, cin_next;
    logic [WORD_W-1:0]  x_reg, x_next;
    logic [WORD_W-1:0]  y_reg, y_next;
    logic [WORD_W-1:0]  rem_reg, rem_next;
    logic [WORD_W-1:0]  quo_reg, quo_next;
    logic [WORD_W-1:0]  dmag_reg, dmag_next;
    logic               qneg_reg, qneg_next;
    logic [STEP_W-1:0]  cnt_reg, cnt_next;
    logic               err_reg, err_next;
    logic [WORD_W-1:0]  res_reg, res_next;

    // shared multiplier, low word only
    logic [WORD_W-1:0]  mul_a, mul_b, prod;
    // divider helpers
    logic [WORD_W-1:0]  dvd, dvd_mag, dsr_mag;
    logic [WORD_W:0]    trial;
    // rounding helpers
    logic [WORD_W-1:0]  q_adj;
    logic [WORD_W:0]    q_half;

    assign cfg_ready = aresetn;
    assign s_ready   = aresetn && (state_reg == ST_IDLE);
    assign m_valid   = (state_reg == ST_OUT);
    assign m_data.result = res_reg;
    assign m_data.status = err_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_code_reg  <= '0;
            p1_value_reg <= '0;
            p2_code_reg  <= '0;
            p2_value_reg <= '0;
            scale_reg    <= CODE_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_P1_CODE:  p1_code_reg  <= cfg_data[CODE_W-1:0];
                REG_P1_VALUE: p1_value_reg <= cfg_data;
                REG_P2_CODE:  p2_code_reg  <= cfg_data[CODE_W-1:0];
                REG_P2_VALUE: p2_value_reg <= cfg_data;
                REG_SCALE:    scale_reg    <= cfg_data[CODE_W-1:0];
                default: ;
            endcase
        end
    end

    // multiplier operand select
    always_comb begin
        mul_a = x_reg;
        mul_b = {1'b0, scale_reg};
        case (state_reg)
            ST_MUL: begin
                case (op_reg)
                    OP_TO_CODE: begin
                        mul_a = vin_reg;
                        mul_b = {1'b0, scale_reg};
                    end
                    OP_TO_VAL: begin
                        mul_a = {1'b0, cin_reg};
                        mul_b = gain_reg;
                    end
                    default: begin
                        mul_a = x_reg;
                        mul_b = {1'b0, scale_reg};
                    end
                endcase
            end
            ST_ICPT_A: begin
                mul_a = p1_value_reg;
                mul_b = {1'b0, scale_reg};
            end
            ST_ICPT_B: begin
                mul_a = {1'b0, p1_code_reg};
                mul_b = gain_reg;
            end
            default: ;
        endcase
    end
    assign prod = mul_a * mul_b;

    // divider operand magnitudes: dividend is the doubled, wrapped numerator
    assign dvd     = {x_reg[WORD_W-2:0], 1'b0};
    assign dvd_mag = dvd[WORD_W-1] ? (~dvd + WORD_W'(1)) : dvd;
    assign dsr_mag = y_reg[WORD_W-1] ? (~y_reg + WORD_W'(1)) : y_reg;
    assign trial   = {rem_reg, quo_reg[WORD_W-1]} - {1'b0, dmag_reg};

    // add one away from zero, then halve toward zero
    assign q_adj  = x_reg[WORD_W-1] ? (x_reg - WORD_W'(1)) : (x_reg + WORD_W'(1));
    assign q_half = $signed({q_adj[WORD_W-1], q_adj} + {{WORD_W{1'b0}}, q_adj[WORD_W-1]})
                    >>> 1;

    // state register and datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            gain_reg  <= '0;
            icpt_reg  <= '0;
        end else begin
            state_reg <= state_next;
            gain_reg  <= gain_next;
            icpt_reg  <= icpt_next;
        end
        op_reg   <= op_next;
        vin_reg  <= vin_next;
        cin_reg  <= cin_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dmag_reg <= dmag_next;
        qneg_reg <= qneg_next;
        cnt_reg  <= cnt_next;
        err_reg  <= err_next;
        res_reg  <= res_next;
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        gain_next  = gain_reg;
        icpt_next  = icpt_reg;
        op_next    = op_reg;
        vin_next   = vin_reg;
        cin_next   = cin_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dmag_next  = dmag_reg;
        qneg_next  = qneg_reg;
        cnt_next   = cnt_reg;
        err_next   = err_reg;
        res_next   = res_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next  = opcode_t'(s_data.opcode);
                    vin_next = s_data.value_in;
                    cin_next = s_data.code_in;
                    err_next = 1'b0;
                    res_next = '0;
                    y_next   = (opcode_t'(s_data.opcode) == OP_TO_CODE) ? gain_reg
                                                                        : {1'b0, scale_reg};
                    unique case (opcode_t'(s_data.opcode)) inside
                        OP_COEF:                state_next = ST_PREP;
                        OP_TO_CODE, OP_TO_VAL:  state_next = ST_MUL;
                        default:                state_next = ST_OUT;
                    endcase
                end
            end
            // point differences
            ST_PREP: begin
                x_next     = p2_value_reg - p1_value_reg;
                y_next     = {1'b0, p2_code_reg} - {1'b0, p1_code_reg};
                state_next = ST_MUL;
            end
            ST_MUL: begin
                x_next     = prod;
                state_next = (op_reg == OP_COEF) ? ST_DIV_INIT : ST_ADJ;
            end
            // apply intercept
            ST_ADJ: begin
                x_next     = (op_reg == OP_TO_CODE) ? (x_reg - icpt_reg) : (x_reg + icpt_reg);
                state_next = ST_DIV_INIT;
            end
            ST_DIV_INIT: begin
                rem_next  = '0;
                quo_next  = dvd_mag;
                dmag_next = dsr_mag;
                qneg_next = dvd[WORD_W-1] ^ y_reg[WORD_W-1];
                cnt_next  = '0;
                if (y_reg == '0) begin
                    err_next = 1'b1;
                    if (op_reg == OP_COEF) begin
                        gain_next  = '0;
                        state_next = ST_ICPT_A;
                    end else begin
                        res_next   = '0;
                        state_next = ST_OUT;
                    end
                end else begin
                    state_next = ST_DIV;
                end
            end
            // one restoring step per cycle
            ST_DIV: begin
                quo_next = {quo_reg[WORD_W-2:0], ~trial[WORD_W]};
                rem_next = trial[WORD_W] ? {rem_reg[WORD_W-2:0], quo_reg[WORD_W-1]}
                                         : trial[WORD_W-1:0];
                cnt_next = cnt_reg + STEP_W'(1);
                if (cnt_reg == STEP_W'(WORD_W - 1)) begin
                    state_next = ST_FIX;
                end
            end
            // restore quotient sign
            ST_FIX: begin
                x_next     = qneg_reg ? (~quo_reg + WORD_W'(1)) : quo_reg;
                state_next = ST_RND;
            end
            ST_RND: begin
                if (op_reg == OP_COEF) begin
                    gain_next  = q_half[WORD_W-1:0];
                    state_next = ST_ICPT_A;
                end else begin
                    res_next   = q_half[WORD_W-1:0];
                    state_next = ST_OUT;
                end
            end
            // intercept = p1_value * scale - p1_code * gain
            ST_ICPT_A: begin
                x_next     = prod;
                state_next = ST_ICPT_B;
            end
            ST_ICPT_B: begin
                y_next     = prod;
                state_next = ST_ICPT_C;
            end
            ST_ICPT_C: begin
                icpt_next  = x_reg - y_reg;
                res_next   = gain_reg;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // one word in flight at a time
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("input taken while result pending");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready) else $error("ready after accept");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status |-> m_data.result == '0)
        else $error("nonzero result with division error");

    a_div_length: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV && cnt_reg == STEP_W'(WORD_W - 1) |=> state_reg == ST_FIX)
        else $error("divider step count wrong");

endmodule

// File: tb/sv/tb_two_point_linear_calibration.sv
// self-checking testbench for the two-point linear calibration unit
`timescale 1ns / 1ps

module tb_two_point_linear_calibration;
    import tplc_pkg::*;

    localparam int LIMIT_CYCLES = 1000000;
    localparam logic [CODE_W-1:0] CODE_MAX = {CODE_W{1'b1}};

    // one row of the directed plan: a register write or an input word
    typedef struct {
        logic                 is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [WORD_W-1:0]    data;
        in_item_t             word;
        logic                 typed;
        out_item_t            want;
    } plan_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WORD_W-1:0]    cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    in_item_t             s_data;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    out_item_t            m_data;

    // calibration registers and coefficients as the block should hold them
    logic [CODE_W-1:0]        cal_p1_code;
    logic signed [WORD_W-1:0] cal_p1_value;
    logic [CODE_W-1:0]        cal_p2_code;
    logic signed [WORD_W-1:0] cal_p2_value;
    logic [CODE_W-1:0]        cal_scale;
    logic signed [WORD_W-1:0] cal_gain;
    logic signed [WORD_W-1:0] cal_icpt;

    out_item_t   pending_results[$];
    plan_row_t   test_plan[$];
    out_item_t   oldest_result;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          n_words[4];
    int          n_checked;
    int          n_zero_div;
    int          n_mismatch;
    int          n_settings;
    int          cycle_count;
    int          words_left;
    int          blk_len;
    int          mode;
    logic        last_cfg;
    in_item_t    w;
    logic [WORD_W-1:0] pc1, pv1, pc2, pv2, psc;

    two_point_linear_calibration u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // 50 MHz clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // cycle counter and watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        cycle_count = 0;
        wait (cycle_count >= LIMIT_CYCLES);
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, pending_results.size());
        $display("FAILED: results differ");
        $finish;
    end

    // receiver backpressure
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // rounded division: double, truncate, step away from zero, halve
    function automatic logic signed [WORD_W-1:0] round_div(
        input logic signed [WORD_W-1:0] num,
        input logic signed [WORD_W-1:0] den,
        output logic by_zero
    );
        logic signed [WORD_W-1:0] t;
        longint q;
        by_zero = 1'b0;
        if (den == 0) begin
            by_zero = 1'b1;
            return '0;
        end
        t = num <<< 1;
        q = longint'(t) / longint'(den);
        t = q[WORD_W-1:0];
        t = (t >= 0) ? t + 32'sd1 : t - 32'sd1;
        return t / 32'sd2;
    endfunction

    // expected result of one word; opcode 0 also updates gain and intercept
    function automatic out_item_t calibrate(input in_item_t iw);
        logic signed [WORD_W-1:0] sc, c1, c2, v1, dc, dv, acc, code;
        logic dz;
        out_item_t r;
        sc = {1'b0, cal_scale};
        dz = 1'b0;
        r.result = '0;
        case (opcode_t'(iw.opcode))
            OP_COEF: begin
                c1 = {1'b0, cal_p1_code};
                c2 = {1'b0, cal_p2_code};
                v1 = cal_p1_value;
                dc = c2 - c1;
                dv = (cal_p2_value - v1) * sc;
                cal_gain = round_div(dv, dc, dz);
                cal_icpt = v1 * sc - c1 * cal_gain;
                r.result = cal_gain;
            end
            OP_TO_CODE: begin
                acc = iw.value_in * sc - cal_icpt;
                r.result = round_div(acc, cal_gain, dz);
            end
            OP_TO_VAL: begin
                code = {1'b0, iw.code_in};
                acc = code * cal_gain + cal_icpt;
                r.result = round_div(acc, sc, dz);
            end
            default: ;
        endcase
        r.status = dz;
        return r;
    endfunction

    function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [WORD_W-1:0] data);
        plan_row_t row;
        row = '{is_cfg: 1'b1, idx: idx, data: data, word: '0, typed: 1'b0, want: '0};
        test_plan.push_back(row);
    endfunction

    function automatic void add_item(input opcode_t op, input logic [WORD_W-1:0] v,
                                     input logic [CODE_W-1:0] c, input logic typed = 1'b0,
                                     input logic [WORD_W-1:0] res = '0,
                                     input logic st = 1'b0);
        plan_row_t row;
        row.is_cfg = 1'b0;
        row.idx = '0;
        row.data = '0;
        row.word.opcode = op;
        row.word.value_in = v;
        row.word.code_in = c;
        row.typed = typed;
        row.want.result = res;
        row.want.status = st;
        test_plan.push_back(row);
    endfunction

    // corner values for register settings
    function automatic logic [WORD_W-1:0] extreme_word();
        case ($urandom_range(0, 4))
            0: return 32'h0000_0000;
            1: return 32'h0000_0001;
            2: return 32'h7FFF_FFFF;
            3: return 32'h8000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    // register write; the caller lowers cfg_valid by sending a word
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_P1_CODE:  cal_p1_code = data[CODE_W-1:0];
            REG_P1_VALUE: cal_p1_value = data;
            REG_P2_CODE:  cal_p2_code = data[CODE_W-1:0];
            REG_P2_VALUE: cal_p2_value = data;
            REG_SCALE:    cal_scale = data[CODE_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
    endtask

    // send one word with a random gap; valid stays up for a following word
    task automatic push_word(input in_item_t iw, input logic typed, input out_item_t want);
        out_item_t pred;
        cfg_valid <= 1'b0;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= iw;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pred = calibrate(iw);
        pending_results.push_back(typed ? want : pred);
        n_words[iw.opcode]++;
        @(negedge aclk);
    endtask

    // hold off until every result is back and the block is idle
    task automatic settle_idle();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        n_settings++;
    endtask

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            n_checked++;
            if (m_data.status) n_zero_div++;
            if (pending_results.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("mismatch: unexpected word result=%0d status=%0b",
                             m_data.result, m_data.status);
            end else begin
                oldest_result = pending_results.pop_front();
                if (m_data.result !== oldest_result.result ||
                    m_data.status !== oldest_result.status) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch at word %0d: expected %0d/%0b got %0d/%0b",
                                 n_checked, oldest_result.result, oldest_result.status,
                                 m_data.result, m_data.status);
                end
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cal_p1_code = '0;
        cal_p1_value = '0;
        cal_p2_code = '0;
        cal_p2_value = '0;
        cal_scale = CODE_W'(1);
        cal_gain = '0;
        cal_icpt = '0;
        n_checked = 0;
        n_zero_div = 0;
        n_mismatch = 0;
        n_settings = 1;
        send_idle_pct = 16;
        recv_idle_pct = 78;

        // directed plan
        // reset state: equal codes give a zero divisor
        add_item(OP_COEF, 0, 0, 1'b1, 0, 1'b1);
        add_item(OP_TO_CODE, 5, 0, 1'b1, 0, 1'b1);
        add_item(OP_TO_VAL, 0, CODE_MAX, 1'b1, 0, 1'b0);
        add_item(OP_NOP, 32'hFFFF_FFFF, CODE_MAX, 1'b1, 0, 1'b0);
        // ordinary line with value extremes
        add_cfg(REG_P1_CODE, 100);
        add_cfg(REG_P1_VALUE, -32'sd1000);
        add_cfg(REG_P2_CODE, 1100);
        add_cfg(REG_P2_VALUE, 9000);
        add_cfg(REG_SCALE, 16);
        add_item(OP_COEF, 0, 0);
        add_item(OP_TO_CODE, 32'h7FFF_FFFF, 0);
        add_item(OP_TO_CODE, 32'h8000_0000, 0);
        add_item(OP_TO_CODE, 1000, 0);
        add_item(OP_TO_VAL, 0, 0);
        add_item(OP_TO_VAL, 0, CODE_MAX);
        add_item(OP_TO_VAL, 0, 600);
        // scale of zero
        add_cfg(REG_SCALE, 0);
        add_item(OP_TO_VAL, 0, 5, 1'b1, 0, 1'b1);
        add_item(OP_COEF, 0, 0);
        add_item(OP_TO_CODE, 77, 0, 1'b1, 0, 1'b1);
        // most negative word divided by minus one
        add_cfg(REG_P1_CODE, 1);
        add_cfg(REG_P1_VALUE, 0);
        add_cfg(REG_P2_CODE, 0);
        add_cfg(REG_P2_VALUE, 32'h4000_0000);
        add_cfg(REG_SCALE, 1);
        add_item(OP_COEF, 0, 0);
        add_item(OP_TO_CODE, 32'h4000_0000, 0);
        add_item(OP_TO_VAL, 0, 3);
        // register extremes, code bit 31 masked off
        add_cfg(REG_P1_CODE, 32'hFFFF_FFFF);
        add_cfg(REG_P1_VALUE, 32'h8000_0000);
        add_cfg(REG_P2_CODE, 0);
        add_cfg(REG_P2_VALUE, 32'h7FFF_FFFF);
        add_cfg(REG_SCALE, 32'hFFFF_FFFF);
        add_item(OP_COEF, 0, 0);
        add_item(OP_TO_CODE, 32'hFFFF_FFFF, 0);
        add_item(OP_TO_VAL, 0, CODE_MAX);
        add_item(OP_NOP, 32'h7FFF_FFFF, 0, 1'b1, 0, 1'b0);

        // hold reset, then release it
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // walk the directed plan
        last_cfg = 1'b0;
        foreach (test_plan[i]) begin
            if (test_plan[i].is_cfg) begin
                if (!last_cfg) settle_idle();
                cfg_write(test_plan[i].idx, test_plan[i].data);
            end else begin
                push_word(test_plan[i].word, test_plan[i].typed, test_plan[i].want);
            end
            last_cfg = test_plan[i].is_cfg;
        end

        // random part in three idling phases
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 16;
                    recv_idle_pct = 78;
                end
                1: begin
                    send_idle_pct = 78;
                    recv_idle_pct = 16;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            words_left = (ph == 2) ? 484 : 483;
            while (words_left > 0) begin
                settle_idle();
                // new calibration points
                mode = $urandom_range(0, 99);
                if (mode < 50) begin
                    pc1 = $urandom_range(0, 4095);
                    pc2 = $urandom_range(0, 65535);
                    pv1 = int'($urandom_range(0, 2097152)) - 1048576;
                    pv2 = int'($urandom_range(0, 2097152)) - 1048576;
                    psc = $urandom_range(1, 256);
                end else if (mode < 75) begin
                    pc1 = $urandom;
                    pc2 = $urandom;
                    pv1 = $urandom;
                    pv2 = $urandom;
                    psc = $urandom;
                end else if (mode < 85) begin
                    // equal codes: zero divisor on the coefficients
                    pc1 = $urandom;
                    pc2 = pc1;
                    pv1 = $urandom;
                    pv2 = $urandom;
                    psc = $urandom_range(1, 1024);
                end else begin
                    pc1 = extreme_word();
                    pc2 = extreme_word();
                    pv1 = extreme_word();
                    pv2 = extreme_word();
                    psc = extreme_word();
                end
                cfg_write(REG_P1_CODE, pc1);
                cfg_write(REG_P1_VALUE, pv1);
                cfg_write(REG_P2_CODE, pc2);
                cfg_write(REG_P2_VALUE, pv2);
                cfg_write(REG_SCALE, psc);

                // block of words, coefficients first
                blk_len = $urandom_range(20, 60);
                if (blk_len > words_left) blk_len = words_left;
                for (int k = 0; k < blk_len; k++) begin
                    mode = $urandom_range(0, 99);
                    if (k == 0 || mode < 10) w.opcode = OP_COEF;
                    else if (mode < 50)      w.opcode = OP_TO_CODE;
                    else if (mode < 90)      w.opcode = OP_TO_VAL;
                    else                     w.opcode = OP_NOP;
                    if ($urandom_range(0, 1))
                        w.value_in = $urandom;
                    else
                        w.value_in = int'($urandom_range(0, 2097152)) - 1048576;
                    if ($urandom_range(0, 1))
                        w.code_in = CODE_W'($urandom);
                    else
                        w.code_in = CODE_W'($urandom_range(0, 65535));
                    push_word(w, 1'b0, '0);
                end
                words_left -= blk_len;
            end
        end

        // drain and let the block go quiet
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);

        $display("covered %0d settings: %0d coefficient, %0d to-code, %0d to-value, %0d no-op",
                 n_settings, n_words[OP_COEF], n_words[OP_TO_CODE], n_words[OP_TO_VAL],
                 n_words[OP_NOP]);
        $display("%0d results checked in %0d cycles, %0d zero divisor, %0d mismatches",
                 n_checked, cycle_count, n_zero_div, n_mismatch);
        if (n_mismatch == 0 && pending_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
